// File: rtl/rpd_pkg.sv
// shared constants, types and helpers of the run-length planar image decoder
package rpd_pkg;

    localparam int DIM_W      = 13;
    localparam int LINE_W     = 12;
    localparam int CHAN_W     = 2;
    localparam int CHANS_W    = 3;
    localparam int COUNT_W    = 7;
    localparam int VALUE_W    = 8;
    localparam int ADDR_W     = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int DIM_CAP    = 4096;
    localparam int MAX_CHANS  = 4;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [DIM_W-1:0] WIDTH_LIMIT =
        DIM_W'(MAX_WIDTH < DIM_CAP ? MAX_WIDTH : DIM_CAP);
    localparam logic [DIM_W-1:0] ROWS_LIMIT =
        DIM_W'(MAX_HEIGHT < DIM_CAP ? MAX_HEIGHT : DIM_CAP);
    localparam logic [CHANS_W-1:0] CHANS_LIMIT = CHANS_W'(MAX_CHANS);
    localparam logic [DIM_W-1:0] COLUMN_MAX = '1;

    // control byte layout
    localparam int KIND_BIT = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_MODE = 2'd3;

    // clamped image dimensions
    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   rows;
        logic [CHANS_W-1:0] chans;
    } dims_t;

    // one classified run, front to back
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [DIM_W-1:0]   column;
        logic [COUNT_W-1:0] len;
        logic               scanline_done;
        logic               frame_done;
        logic               length_error;
        logic               zero_address;
        logic [LINE_W-1:0]  line;
        logic [CHAN_W-1:0]  chan;
    } run_cmd_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [CHANS_W-1:0] clamp_chans(input logic [CHANS_W-1:0] v);
        logic [CHANS_W-1:0] r;
        if (v == '0)
            r = CHANS_W'(1);
        else if (v > CHANS_LIMIT)
            r = CHANS_LIMIT;
        else
            r = v;
        return r;
    endfunction

endpackage

// File: rtl/rpd_byte_if.sv
// byte stream channel: valid, ready and one stored data byte
interface rpd_byte_if;
    import rpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// File: rtl/rpd_run_if.sv
// run descriptor channel: valid, ready and one write descriptor
interface rpd_run_if;
    import rpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] pixel_value;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COUNT_W-1:0] run_length;
    logic               scanline_done;
    logic               frame_done;
    logic               length_error;

    modport source (output valid, output pixel_value, output pixel_address,
                    output run_length, output scanline_done, output frame_done,
                    output length_error, input ready);
    modport sink (input valid, input pixel_value, input pixel_address,
                  input run_length, input scanline_done, input frame_done,
                  input length_error, output ready);
endinterface

// File: rtl/rpd_front.sv
// front end: takes bytes, tracks decode phase and position, emits run commands
module rpd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  rpd_pkg::dims_t    dims,
    input  logic              compressed,
    input  logic              queue_ready,
    output logic              push,
    output rpd_pkg::run_cmd_t cmd,
    rpd_byte_if.sink          byte_chan
);
    import rpd_pkg::*;

    typedef enum logic [2:0] {
        PH_CTRL    = 3'b001,
        PH_REPEAT  = 3'b010,
        PH_LITERAL = 3'b100
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [DIM_W-1:0]   column_reg, column_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [CHAN_W-1:0]  chan_reg, chan_next;
    logic               err_seen_reg, err_seen_next;

    logic               accept;
    logic               has_result;
    logic               end_line;
    logic [COUNT_W-1:0] step;
    logic [DIM_W:0]     sum;
    logic               over;
    logic [DIM_W-1:0]   col_sat;
    logic [DIM_W-1:0]   line_inc;
    logic               line_wrap;
    logic [CHANS_W-1:0] chan_inc;
    logic               chan_wrap;
    logic [COUNT_W-1:0] count_dec;
    logic [VALUE_W-1:0] b;

    assign b               = byte_chan.data_byte;
    assign byte_chan.ready = queue_ready;
    assign accept          = byte_chan.valid && queue_ready;
    assign push            = accept && has_result;

    // column advance of the byte in hand
    assign step    = (compressed && phase_reg == PH_REPEAT) ? count_reg : COUNT_W'(1);
    assign sum     = (DIM_W+1)'(column_reg) + (DIM_W+1)'(step);
    assign over    = sum > (DIM_W+1)'(dims.width);
    assign col_sat = (sum > (DIM_W+1)'(COLUMN_MAX)) ? COLUMN_MAX : sum[DIM_W-1:0];

    // scanline and plane stepping
    assign line_inc  = DIM_W'(line_reg) + DIM_W'(1);
    assign line_wrap = line_inc >= dims.rows;
    assign chan_inc  = CHANS_W'(chan_reg) + CHANS_W'(1);
    assign chan_wrap = chan_inc >= dims.chans;

    assign count_dec = count_reg - COUNT_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        column_next   = column_reg;
        line_next     = line_reg;
        chan_next     = chan_reg;
        err_seen_next = err_seen_reg;
        has_result    = 1'b0;
        end_line      = 1'b0;

        cmd.value         = b;
        cmd.column        = column_reg;
        cmd.len           = '0;
        cmd.scanline_done = 1'b0;
        cmd.frame_done    = 1'b0;
        cmd.length_error  = 1'b0;
        cmd.zero_address  = 1'b0;
        cmd.line          = line_reg;
        cmd.chan          = chan_reg;

        if (!compressed)
        begin
            has_result       = 1'b1;
            cmd.len          = over ? '0 : COUNT_W'(1);
            cmd.length_error = over;
            column_next      = col_sat;
            err_seen_next    = err_seen_reg | over;
            if (col_sat >= dims.width)
            begin
                cmd.scanline_done = 1'b1;
                cmd.frame_done    = line_wrap && chan_wrap;
                cmd.length_error  = err_seen_reg | over | (col_sat != dims.width);
                end_line          = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_REPEAT:
                begin
                    has_result       = 1'b1;
                    cmd.len          = over ? '0 : count_reg;
                    cmd.length_error = over;
                    column_next      = col_sat;
                    err_seen_next    = err_seen_reg | over;
                    count_next       = '0;
                    phase_next       = PH_CTRL;
                end
                PH_LITERAL:
                begin
                    has_result       = 1'b1;
                    cmd.len          = over ? '0 : COUNT_W'(1);
                    cmd.length_error = over;
                    column_next      = col_sat;
                    err_seen_next    = err_seen_reg | over;
                    count_next       = count_dec;
                    if (count_dec == '0)
                        phase_next = PH_CTRL;
                end
                default:
                begin
                    // control byte, also for a broken phase code
                    phase_next = PH_CTRL;
                    if (b == '0)
                    begin
                        has_result        = 1'b1;
                        cmd.value         = '0;
                        cmd.zero_address  = 1'b1;
                        cmd.scanline_done = 1'b1;
                        cmd.frame_done    = line_wrap && chan_wrap;
                        cmd.length_error  = err_seen_reg | (column_reg != dims.width);
                        end_line          = 1'b1;
                    end
                    else if (b[COUNT_W-1:0] != '0)
                    begin
                        count_next = b[COUNT_W-1:0];
                        phase_next = b[KIND_BIT] ? PH_LITERAL : PH_REPEAT;
                    end
                end
            endcase
        end

        if (end_line)
        begin
            column_next   = '0;
            err_seen_next = 1'b0;
            phase_next    = PH_CTRL;
            count_next    = '0;
            if (line_wrap)
            begin
                line_next = '0;
                chan_next = chan_wrap ? '0 : chan_inc[CHAN_W-1:0];
            end
            else
            begin
                line_next = line_inc[LINE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CTRL;
            count_reg    <= '0;
            column_reg   <= '0;
            line_reg     <= '0;
            chan_reg     <= '0;
            err_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            column_reg   <= column_next;
            line_reg     <= line_next;
            chan_reg     <= chan_next;
            err_seen_reg <= err_seen_next;
        end
    end

endmodule

// File: rtl/rpd_queue.sv
// short command queue between front and back
module rpd_queue #(
    parameter int DEPTH = rpd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rpd_pkg::run_cmd_t push_cmd,
    output logic              push_ready,
    input  logic              pop,
    output logic              pop_valid,
    output rpd_pkg::run_cmd_t pop_cmd
);
    import rpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_cmd_t         entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign push_ready = fill_reg != FULL_CNT;
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   fill_next = fill_reg + CNT_W'(1);
            2'b01:   fill_next = fill_reg - CNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

endmodule

// File: rtl/rpd_back.sv
// back end: address pipeline and output register for run descriptors
module rpd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rpd_pkg::dims_t    dims,
    input  logic              cmd_valid,
    input  rpd_pkg::run_cmd_t cmd,
    output logic              cmd_pop,
    rpd_run_if.source         run_chan
);
    import rpd_pkg::*;

    logic                      s1_valid_reg, s2_valid_reg, out_valid_reg;
    run_cmd_t                  s1_cmd_reg, s2_cmd_reg;
    logic [ADDR_W-1:0]         s1_prod_reg, s2_base_reg;
    logic [VALUE_W-1:0]        value_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [COUNT_W-1:0]        len_reg;
    logic                      sd_reg, fd_reg, err_reg;

    logic                      adv_out, adv_s2, adv_s1;
    logic [ADDR_W-1:0]         row;
    logic [ADDR_W+DIM_W-1:0]   row_prod;
    logic [ADDR_W+CHANS_W-1:0] chan_prod;
    logic [ADDR_W-1:0]         addr;

    assign adv_out = !out_valid_reg || run_chan.ready;
    assign adv_s2  = !s2_valid_reg || adv_out;
    assign adv_s1  = !s1_valid_reg || adv_s2;
    assign cmd_pop = cmd_valid && adv_s1;

    // image row is flipped: stored scanline s lands on row rows-1-s, wraps mod 2^26
    assign row      = ADDR_W'(dims.rows) - ADDR_W'(1) - ADDR_W'(cmd.line);
    assign row_prod = row * dims.width;

    assign chan_prod = s2_base_reg * dims.chans;
    assign addr      = s2_cmd_reg.zero_address ? '0
                       : chan_prod[ADDR_W-1:0] + ADDR_W'(s2_cmd_reg.chan);

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s1_cmd_reg  <= cmd;
            s1_prod_reg <= row_prod[ADDR_W-1:0];
        end
        if (s1_valid_reg && adv_s2)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_base_reg <= s1_prod_reg + ADDR_W'(s1_cmd_reg.column);
        end
        if (s2_valid_reg && adv_out)
        begin
            value_reg <= s2_cmd_reg.value;
            addr_reg  <= addr;
            len_reg   <= s2_cmd_reg.len;
            sd_reg    <= s2_cmd_reg.scanline_done;
            fd_reg    <= s2_cmd_reg.frame_done;
            err_reg   <= s2_cmd_reg.length_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
                s1_valid_reg <= cmd_valid;
            if (adv_s2)
                s2_valid_reg <= s1_valid_reg;
            if (adv_out)
                out_valid_reg <= s2_valid_reg;
        end
    end

    assign run_chan.valid         = out_valid_reg;
    assign run_chan.pixel_value   = value_reg;
    assign run_chan.pixel_address = addr_reg;
    assign run_chan.run_length    = len_reg;
    assign run_chan.scanline_done = sd_reg;
    assign run_chan.frame_done    = fd_reg;
    assign run_chan.length_error  = err_reg;

endmodule

// File: rtl/rle_planar_image_decoder_core.sv
// top level of the run-length planar image decoder
//
//  channel    dir  modport  beat
//  byte_chan  in   sink     one stored scanline byte (data_byte)
//  run_chan   out  source   one write descriptor (value, address, length, flags)
//  cfg_*      in   -        register write, no handshake, no read-back
//
//  one byte per cycle sustained while the queue has room; a beat with a result
//  passes from the queue through the back stages into the output register
//  the front updates phase, count and column for each byte taken; the back
//  is three register stages: row product, column add, channel product
//  a four-deep queue lets the front keep taking bytes while the output stalls
//  rst_n clears all control state and loads the register reset values
//  control bytes that start a run give no beat and never occupy the queue
module rle_planar_image_decoder_core #(
    parameter int QUEUE_DEPTH = rpd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_data,
    rpd_byte_if.sink                       byte_chan,
    rpd_run_if.source                      run_chan
);
    import rpd_pkg::*;

    // configuration registers
    logic [DIM_W-1:0]   row_width_reg;
    logic [DIM_W-1:0]   row_count_reg;
    logic [CHANS_W-1:0] channel_count_reg;
    logic               compressed_reg;

    dims_t    dims;
    logic     push, queue_ready;
    logic     pop, pop_valid;
    run_cmd_t push_cmd, pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg     <= DIM_W'(1);
            row_count_reg     <= DIM_W'(1);
            channel_count_reg <= CHANS_W'(1);
            compressed_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_WIDTH:       row_width_reg     <= cfg_data[DIM_W-1:0];
                CFG_ROW_COUNT:       row_count_reg     <= cfg_data[DIM_W-1:0];
                CFG_CHANNEL_COUNT:   channel_count_reg <= cfg_data[CHANS_W-1:0];
                CFG_COMPRESSED_MODE: compressed_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // out of range settings act as clamped to the supported dimensions
    assign dims.width = clamp_dim(row_width_reg, WIDTH_LIMIT);
    assign dims.rows  = clamp_dim(row_count_reg, ROWS_LIMIT);
    assign dims.chans = clamp_chans(channel_count_reg);

    // front: byte classification and scanline bookkeeping
    rpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .dims        (dims),
        .compressed  (compressed_reg),
        .queue_ready (queue_ready),
        .push        (push),
        .cmd         (push_cmd),
        .byte_chan   (byte_chan)
    );

    // decoupling queue
    rpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (queue_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    // back: address arithmetic and output register
    rpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims      (dims),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .run_chan  (run_chan)
    );

endmodule

// File: rtl/rpd_checker.sv
// port level checks of the decoder output, bound to the top level
module rpd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [rpd_pkg::VALUE_W-1:0] pixel_value,
    input logic [rpd_pkg::ADDR_W-1:0]  pixel_address,
    input logic [rpd_pkg::COUNT_W-1:0] run_length,
    input logic                        scanline_done,
    input logic                        frame_done,
    input logic                        length_error
);
    import rpd_pkg::*;

    // a stalled beat keeps its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_value)
            && $stable(pixel_address) && $stable(run_length)
            && $stable(scanline_done) && $stable(frame_done) && $stable(length_error))
        else $error("stalled beat changed");

    // a frame ends only with a scanline end
    a_frame_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> scanline_done)
        else $error("frame_done without scanline_done");

    // an overflowing run is reported with no write
    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !scanline_done && run_length != '0 |-> !length_error)
        else $error("length_error on a run that writes");

    // no beat straight out of reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("beat right after reset");

endmodule

bind rle_planar_image_decoder_core rpd_checker u_rpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (run_chan.valid),
    .out_ready     (run_chan.ready),
    .pixel_value   (run_chan.pixel_value),
    .pixel_address (run_chan.pixel_address),
    .run_length    (run_chan.run_length),
    .scanline_done (run_chan.scanline_done),
    .frame_done    (run_chan.frame_done),
    .length_error  (run_chan.length_error)
);

// File: tb/sv/rpd_decode_checker.sv
// checker for the run-length planar image decoder: predicts each run descriptor and compares beats
`timescale 1ns / 1ps
module rpd_decode_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_data,
    rpd_byte_if                            byte_chan,
    rpd_run_if                             run_chan,
    output int                             failures,
    output int                             pending
);
    import rpd_pkg::*;

    typedef enum logic [2:0] {
        LP_CONTROL = 3'b001,
        LP_REPEAT  = 3'b010,
        LP_LITERAL = 3'b100
    } line_phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [ADDR_W-1:0]  address;
        logic [COUNT_W-1:0] length;
        logic               line_end;
        logic               frame_end;
        logic               length_error;
    } run_beat_t;

    // register copies
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   rows_reg;
    logic [CHANS_W-1:0] chans_reg;
    logic               coded_reg;

    // decode state
    line_phase_t        phase;
    logic [COUNT_W-1:0] count_left;
    logic [DIM_W-1:0]   column;
    logic [LINE_W-1:0]  line_idx;
    logic [CHAN_W-1:0]  chan_idx;
    logic               line_bad;

    run_beat_t runs_due[$];
    int        fail_count = 0;
    int        due_count = 0;

    assign failures = fail_count;
    assign pending  = due_count;

    function automatic int limit_to(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input int col);
        bit [31:0] row;
        bit [63:0] flat;
        // a row index past the plane height wraps through 32 bits
        row  = 32'(limit_to(int'(rows_reg), int'(ROWS_LIMIT))) - 32'd1 - 32'(line_idx);
        flat = (64'(row) * 64'(limit_to(int'(width_reg), int'(WIDTH_LIMIT))) + 64'(col))
               * 64'(limit_to(int'(chans_reg), MAX_CHANS)) + 64'(chan_idx);
        return flat[ADDR_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] col_after(input int step);
        int s;
        s = int'(column) + step;
        return (s > int'(COLUMN_MAX)) ? COLUMN_MAX : DIM_W'(s);
    endfunction

    // closes the scanline, gives the frame end flag
    function automatic logic close_line();
        int   next_line;
        int   next_chan;
        logic frame;
        frame     = 1'b0;
        next_line = int'(line_idx) + 1;
        if (next_line >= limit_to(int'(rows_reg), int'(ROWS_LIMIT)))
        begin
            next_line = 0;
            next_chan = int'(chan_idx) + 1;
            if (next_chan >= limit_to(int'(chans_reg), MAX_CHANS))
            begin
                next_chan = 0;
                frame     = 1'b1;
            end
            chan_idx = CHAN_W'(next_chan);
        end
        line_idx   = LINE_W'(next_line);
        column     = '0;
        line_bad   = 1'b0;
        phase      = LP_CONTROL;
        count_left = '0;
        return frame;
    endfunction

    // one stored byte in, at most one run descriptor out
    function automatic bit decode_byte(input logic [VALUE_W-1:0] b, output run_beat_t beat);
        int w;
        int n;
        bit over;
        w    = limit_to(int'(width_reg), int'(WIDTH_LIMIT));
        beat = '0;
        if (!coded_reg)
        begin
            over         = int'(column) + 1 > w;
            beat.value   = b;
            beat.address = addr_of(int'(column));
            beat.length  = over ? '0 : COUNT_W'(1);
            column       = col_after(1);
            if (over)
                line_bad = 1'b1;
            if (int'(column) >= w)
            begin
                beat.length_error = line_bad | (int'(column) != w);
                beat.line_end     = 1'b1;
                beat.frame_end    = close_line();
            end
            else
                beat.length_error = over;
            return 1'b1;
        end
        case (phase)
            LP_REPEAT:
            begin
                n                 = int'(count_left);
                over              = int'(column) + n > w;
                beat.value        = b;
                beat.address      = addr_of(int'(column));
                beat.length       = over ? '0 : COUNT_W'(n);
                beat.length_error = over;
                if (over)
                    line_bad = 1'b1;
                column     = col_after(n);
                count_left = '0;
                phase      = LP_CONTROL;
                return 1'b1;
            end
            LP_LITERAL:
            begin
                over              = int'(column) + 1 > w;
                beat.value        = b;
                beat.address      = addr_of(int'(column));
                beat.length       = over ? '0 : COUNT_W'(1);
                beat.length_error = over;
                if (over)
                    line_bad = 1'b1;
                column     = col_after(1);
                count_left = count_left - 1'b1;
                if (count_left == '0)
                    phase = LP_CONTROL;
                return 1'b1;
            end
            default:
            begin
                // zero control byte closes the scanline
                if (b == '0)
                begin
                    beat.length_error = line_bad | (int'(column) != w);
                    beat.line_end     = 1'b1;
                    beat.frame_end    = close_line();
                    return 1'b1;
                end
                phase = LP_CONTROL;
                if (b[KIND_BIT-1:0] == '0)
                    return 1'b0;
                count_left = b[KIND_BIT-1:0];
                phase      = b[KIND_BIT] ? LP_LITERAL : LP_REPEAT;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report(input string field, input longint unsigned got,
                          input longint unsigned want);
        $display("rpd check at %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        run_beat_t want;
        run_beat_t made;
        if (!rst_n)
        begin
            width_reg  = DIM_W'(1);
            rows_reg   = DIM_W'(1);
            chans_reg  = CHANS_W'(1);
            coded_reg  = 1'b0;
            phase      = LP_CONTROL;
            count_left = '0;
            column     = '0;
            line_idx   = '0;
            chan_idx   = '0;
            line_bad   = 1'b0;
            runs_due.delete();
            due_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROW_WIDTH:       width_reg = cfg_data[DIM_W-1:0];
                    CFG_ROW_COUNT:       rows_reg  = cfg_data[DIM_W-1:0];
                    CFG_CHANNEL_COUNT:   chans_reg = cfg_data[CHANS_W-1:0];
                    CFG_COMPRESSED_MODE: coded_reg = cfg_data[0];
                    default: ;
                endcase
            end
            // output beats first, so a fresh expectation never hides a stray beat
            if (run_chan.valid && run_chan.ready)
            begin
                if (runs_due.size() == 0)
                    report("beat with nothing due, pixel_address", run_chan.pixel_address, 0);
                else
                begin
                    want = runs_due.pop_front();
                    if (run_chan.pixel_value !== want.value)
                        report("pixel_value", run_chan.pixel_value, want.value);
                    if (run_chan.pixel_address !== want.address)
                        report("pixel_address", run_chan.pixel_address, want.address);
                    if (run_chan.run_length !== want.length)
                        report("run_length", run_chan.run_length, want.length);
                    if (run_chan.scanline_done !== want.line_end)
                        report("scanline_done", run_chan.scanline_done, want.line_end);
                    if (run_chan.frame_done !== want.frame_end)
                        report("frame_done", run_chan.frame_done, want.frame_end);
                    if (run_chan.length_error !== want.length_error)
                        report("length_error", run_chan.length_error, want.length_error);
                end
            end
            if (byte_chan.valid && byte_chan.ready)
            begin
                if (decode_byte(byte_chan.data_byte, made))
                    runs_due.push_back(made);
            end
            due_count <= runs_due.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// testbench top: clock, reset, register settings, byte stimulus and the verdict
`timescale 1ns / 1ps
module tb_top;
    import rpd_pkg::*;

    // covers a couple of thousand bytes with random idle gaps on either side,
    // plus the pipe
    localparam int CYCLE_LIMIT   = 500000;
    // three pipe stages and the four-deep queue, with a little margin
    localparam int SETTLE_CYCLES = 8;
    localparam int GAP_MAX       = 13;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 100;

    // control byte kinds and the line terminator
    localparam bit                 KIND_REPEAT  = 1'b0;
    localparam bit                 KIND_LITERAL = 1'b1;
    localparam logic [VALUE_W-1:0] LINE_END     = '0;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int failures;
    int pending;
    int cycle_count = 0;
    int line_cols   = 1;
    // bytes taken by the decoder so far
    int bytes_sent  = 0;

    // per side: when set, that side runs without idle cycles for a stretch
    bit src_calm = 1'b0;
    bit snk_calm = 1'b0;

    rpd_byte_if byte_chan ();
    rpd_run_if  run_chan ();

    rle_planar_image_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_chan (byte_chan),
        .run_chan  (run_chan)
    );

    // watches both channels and the register port, predicts and compares
    rpd_decode_checker run_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_chan (byte_chan),
        .run_chan  (run_chan),
        .failures  (failures),
        .pending   (pending)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rle_planar_image_decoder_core: mismatch");
            $finish;
        end
    end

    // idle cycles before the next beat on one side; now and then flip into or
    // out of a stretch with no idling
    function automatic int next_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, GAP_MAX));
    endfunction

    // control byte: kind in the top bit, count below
    function automatic logic [VALUE_W-1:0] ctrl_byte(input bit kind, input int n);
        return {kind, 7'(n)};
    endfunction

    // one byte beat; valid stays high on return so back-to-back beats need no dip
    task automatic push_byte(input logic [VALUE_W-1:0] value);
        int gap;
        gap = next_gap(src_calm);
        if (gap > 0)
        begin
            byte_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_chan.data_byte <= value;
        byte_chan.valid     <= 1'b1;
        do
            @(posedge clk);
        while (!(byte_chan.valid && byte_chan.ready));
        bytes_sent++;
    endtask

    // stop sending and wait until every due beat is out, then let the pipe
    // empty of anything still travelling
    task automatic settle();
        byte_chan.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    // all four registers, only once the decoder is idle
    task automatic apply_setting(input int width, input int rows, input int chans,
                                 input bit coded);
        settle();
        write_reg(CFG_ROW_WIDTH, width);
        write_reg(CFG_ROW_COUNT, rows);
        write_reg(CFG_CHANNEL_COUNT, chans);
        write_reg(CFG_COMPRESSED_MODE, int'(coded));
        cfg_we <= 1'b0;
        // row length the decoder will actually use, for shaping coded lines
        line_cols = (width < 1) ? 1 : ((width > int'(WIDTH_LIMIT)) ? int'(WIDTH_LIMIT) : width);
    endtask

    // one coded scanline of random runs; a rough line may carry no-op controls,
    // stray bytes, an overrunning run or stop short
    task automatic send_coded_line(input bit rough);
        int col;
        int n;
        int cap;
        bit lit;
        col = 0;
        if (rough && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        while (col < line_cols)
        begin
            if (rough && $urandom_range(0, 9) == 0)
                push_byte(ctrl_byte(KIND_LITERAL, 0));
            // wide rows lean on repeats so a line stays a few hundred bytes
            lit = (line_cols > 256) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 1) == 0);
            cap = line_cols - col;
            if (cap > 127)
                cap = 127;
            if (lit && line_cols > 256 && cap > 4)
                cap = 4;
            n = $urandom_range(1, cap);
            if (rough && $urandom_range(0, 7) == 0)
                n = $urandom_range(1, 127);
            if (lit)
            begin
                push_byte(ctrl_byte(KIND_LITERAL, n));
                repeat (n) push_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                push_byte(ctrl_byte(KIND_REPEAT, n));
                push_byte(8'($urandom_range(0, 255)));
            end
            col += n;
            if (rough && $urandom_range(0, 11) == 0)
                break;
        end
        push_byte(LINE_END);
    endtask

    // an out of range or extreme dimension
    function automatic int odd_dim();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 4096;
            2: return 8191;
            default: return int'($urandom_range(0, 8191));
        endcase
    endfunction

    // result side: random stall before each beat, sometimes none for a while
    initial
    begin : run_sink
        int stall;
        run_chan.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            stall = next_gap(snk_calm);
            if (stall > 0)
            begin
                run_chan.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            run_chan.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(run_chan.valid && run_chan.ready));
        end
    end

    initial
    begin : stimulus
        int w;
        int r;
        int c;
        bit coded;
        int phase_end;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_ROW_WIDTH;
        cfg_data            <= '0;
        byte_chan.valid     <= 1'b0;
        byte_chan.data_byte <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: raw, one pixel, one row, one channel, so every byte is
        // a whole scanline and a whole frame
        push_byte(8'h00);
        push_byte(8'hFF);

        // three wide, one row per plane, four planes: each line moves one plane on
        apply_setting(3, 1, 4, 1'b1);
        // clean line: repeat, literal, a literal of count zero doing nothing, end
        push_byte(ctrl_byte(KIND_REPEAT, 2));
        push_byte(8'hAA);
        push_byte(ctrl_byte(KIND_LITERAL, 1));
        push_byte(8'h55);
        push_byte(ctrl_byte(KIND_LITERAL, 0));
        push_byte(LINE_END);
        // longest repeat runs past the row end
        push_byte(ctrl_byte(KIND_REPEAT, 127));
        push_byte(8'h11);
        push_byte(LINE_END);
        // literal run of four into a three wide row, last byte overflows
        push_byte(ctrl_byte(KIND_LITERAL, 4));
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h04);
        push_byte(8'h08);
        push_byte(LINE_END);

        // last plane, clamped widest row, top row of a 4096 row image: the final
        // literal lands on the highest byte address
        apply_setting(8191, 4096, 4, 1'b1);
        repeat (32)
        begin
            push_byte(ctrl_byte(KIND_REPEAT, 127));
            push_byte(8'($urandom_range(0, 255)));
        end
        push_byte(ctrl_byte(KIND_REPEAT, 31));
        push_byte(8'($urandom_range(0, 255)));
        push_byte(ctrl_byte(KIND_LITERAL, 1));
        push_byte(8'($urandom_range(0, 255)));
        push_byte(LINE_END);
        // short line ends with a length error
        push_byte(ctrl_byte(KIND_REPEAT, 1));
        push_byte(8'hFF);
        push_byte(LINE_END);

        // row count now below the scanline index: row goes negative and the
        // address wraps; the line end also closes the frame
        apply_setting(4, 1, 4, 1'b0);
        repeat (4) push_byte(8'($urandom_range(0, 255)));
        // half a raw line, then the rest of it coded from the same column
        push_byte(8'h80);
        push_byte(8'h7F);
        apply_setting(4, 1, 1, 1'b1);
        push_byte(ctrl_byte(KIND_REPEAT, 2));
        push_byte(8'hC3);
        push_byte(LINE_END);

        // random phases; the first few pin the register extremes
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    w = 8191; r = 8191; c = 7; coded = 1'b0;
                end
                1:
                begin
                    w = 0; r = 0; c = 0; coded = 1'b1;
                end
                2:
                begin
                    w = 4096; r = 4096; c = 5; coded = 1'b1;
                end
                default:
                begin
                    w     = ($urandom_range(0, 5) == 0) ? odd_dim() : int'($urandom_range(1, 24));
                    r     = ($urandom_range(0, 4) == 0) ? odd_dim() : int'($urandom_range(1, 3));
                    c     = $urandom_range(0, 7);
                    coded = ($urandom_range(0, 2) != 0);
                end
            endcase
            apply_setting(w, r, c, coded);
            // raw phases usually stop mid-line, so the next setting picks up there
            phase_end = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < phase_end)
            begin
                if (coded)
                    send_coded_line($urandom_range(0, 3) == 0);
                else
                    push_byte(8'($urandom_range(0, 255)));
            end
        end

        settle();
        if (failures == 0)
            $display("rle_planar_image_decoder_core: match");
        else
            $display("rle_planar_image_decoder_core: mismatch");
        $finish;
    end

endmodule
